@@ design/msett_pkg.sv @@
`timescale 1ns / 1ps
package msett_pkg;

  // set geometry
  localparam int ENTRIES   = 16;
  localparam int KEY_WIDTH = 32;

  // port widths fixed by the interface
  localparam int IN_KEY_W = 32;
  localparam int COUNT_W  = 5;

  // operation codes
  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic act;
    logic ins;
    logic rem;
    logic hit;
    logic free_seen;
  } tok_t;

  // commands broadcast from the controller to every cell
  typedef struct packed {
    logic commit;
    logic cancel;
    logic clear;
  } ctl_t;

endpackage

@@ design/msett_cell.sv @@
`timescale 1ns / 1ps
module msett_cell
  import msett_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  ctl_t                 ctl_i,
  input  tok_t                 tok_i,
  output tok_t                 tok_o
);

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 valid_r, valid_nxt;
  logic                 pend_r, pend_nxt;
  tok_t                 tok_r, tok_nxt;
  logic                 match;

  // compare against the broadcast key
  assign match = valid_r && (key_r == key_i);

  // token handling and broadcast commands
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    tok_nxt   = tok_i;
    if (tok_i.act) begin
      tok_nxt.hit       = tok_i.hit | match;
      tok_nxt.free_seen = tok_i.free_seen | ~valid_r;
      if (tok_i.rem && match) begin
        valid_nxt = 1'b0;
      end
      // lowest free slot reserves itself; valid rises only on commit
      if (tok_i.ins && !valid_r && !tok_i.free_seen) begin
        pend_nxt = 1'b1;
        key_nxt  = key_i;
      end
    end
    if (ctl_i.commit && pend_r) begin
      valid_nxt = 1'b1;
      pend_nxt  = 1'b0;
    end
    if (ctl_i.cancel) begin
      pend_nxt = 1'b0;
    end
    if (ctl_i.clear) begin
      valid_nxt = 1'b0;
      pend_nxt  = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // stored key
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign tok_o = tok_r;

endmodule

@@ design/msett_ctrl.sv @@
`timescale 1ns / 1ps
module msett_ctrl
  import msett_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_mode,
  input  logic [IN_KEY_W-1:0]  in_key,
  output logic                 busy,
  output logic                 out_strobe,
  output logic                 out_was_present,
  output logic                 out_rejected_full,
  output logic [COUNT_W-1:0]   out_count,
  output logic [KEY_WIDTH-1:0] key_o,
  output ctl_t                 ctl_o,
  output tok_t                 tok_o,
  input  tok_t                 tok_last_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t               state_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [1:0]           mode_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 strobe_r;
  logic                 was_r;
  logic                 rej_r;
  ctl_t                 ctl_r;
  tok_t                 tok_r;
  logic                 take;
  logic                 ins_new;

  assign busy    = (state_r != ST_IDLE);
  assign take    = start && !busy;
  assign ins_new = (mode_r == MODE_INSERT) && !tok_last_i.hit;

  // sequencer with registered results and broadcasts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= MODE_LOOKUP;
      count_r  <= '0;
      strobe_r <= 1'b0;
      was_r    <= 1'b0;
      rej_r    <= 1'b0;
      ctl_r    <= '0;
      tok_r    <= '0;
    end else begin
      strobe_r <= 1'b0;
      ctl_r    <= '0;
      tok_r    <= '0;
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            mode_r <= in_mode;
            if (in_mode == MODE_CLEAR) begin
              ctl_r.clear <= 1'b1;
              count_r     <= '0;
              was_r       <= 1'b0;
              rej_r       <= 1'b0;
              strobe_r    <= 1'b1;
            end else begin
              tok_r.act <= 1'b1;
              tok_r.ins <= (in_mode == MODE_INSERT);
              tok_r.rem <= (in_mode == MODE_REMOVE);
              state_r   <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (tok_last_i.act) begin
            was_r    <= tok_last_i.hit;
            rej_r    <= ins_new && !tok_last_i.free_seen;
            strobe_r <= 1'b1;
            state_r  <= ST_IDLE;
            if (ins_new && tok_last_i.free_seen) begin
              ctl_r.commit <= 1'b1;
              count_r      <= count_r + COUNT_W'(1);
            end else begin
              ctl_r.cancel <= 1'b1;
            end
            if ((mode_r == MODE_REMOVE) && tok_last_i.hit && (count_r != '0)) begin
              count_r <= count_r - COUNT_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // key held steady for the whole walk
  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= in_key[KEY_WIDTH-1:0];
    end
  end

  assign key_o             = key_r;
  assign ctl_o             = ctl_r;
  assign tok_o             = tok_r;
  assign out_strobe        = strobe_r;
  assign out_was_present   = was_r;
  assign out_rejected_full = rej_r;
  assign out_count         = count_r;

  // a rejected insert never reports the key as present
  a_rej_not_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_was_present && out_rejected_full))
    else $error("rejected insert reported as present");

  // the token leaves the chain only during a walk
  a_tok_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last_i.act |-> (state_r == ST_WALK))
    else $error("token left chain outside a walk");

  // commit, cancel and clear are exclusive
  a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctl_o.commit, ctl_o.cancel, ctl_o.clear}) <= 1)
    else $error("conflicting cell commands");

  // held count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_count <= COUNT_W'(ENTRIES))
    else $error("count beyond capacity");

endmodule

@@ design/membership_set_table.sv @@
`timescale 1ns / 1ps
// membership set table: a set of up to ENTRIES keys held in a chain of cells
//
// input channel: an operation (in_mode, in_key) transfers at a rising edge
// with start high and busy low. modes are lookup, insert, remove and clear.
// result channel: out_strobe marks one cycle that carries out_was_present,
// out_rejected_full and out_count; the receiver takes it in that cycle and
// cannot stall it.
//
// lookup, insert and remove send a token down the cell chain, one cell per
// cycle; the result strobe follows once the token leaves the last cell, and
// busy drops in the strobe cycle, so no new operation is taken before the
// strobe; the chain length sets how long the walk lasts. an insert reserves
// the lowest free cell on the way and commits it once the walk shows the key
// absent. clear answers in the cycle after the transfer and busy stays low,
// so the next operation may follow in the very next cycle.
//
// reset drops every valid bit and the count at once; no clearing pass.
module membership_set_table
  import msett_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [IN_KEY_W-1:0] in_key,
  output logic                out_strobe,
  output logic                out_was_present,
  output logic                out_rejected_full,
  output logic [COUNT_W-1:0]  out_count
);

  logic [KEY_WIDTH-1:0] key_w;
  ctl_t                 ctl_w;
  tok_t                 tok_w [ENTRIES+1];

  // sequencer
  msett_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_mode           (in_mode),
    .in_key            (in_key),
    .busy              (busy),
    .out_strobe        (out_strobe),
    .out_was_present   (out_was_present),
    .out_rejected_full (out_rejected_full),
    .out_count         (out_count),
    .key_o             (key_w),
    .ctl_o             (ctl_w),
    .tok_o             (tok_w[0]),
    .tok_last_i        (tok_w[ENTRIES])
  );

  // cell chain, slot 0 first
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    msett_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .key_i (key_w),
      .ctl_i (ctl_w),
      .tok_i (tok_w[i]),
      .tok_o (tok_w[i+1])
    );
  end

endmodule
